// ===== src/vqn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqn_pkg
// Shared widths, types and constants of the vector / quaternion normalizer.
// ----------------------------------------------------------------------------
package vqn_pkg;
	localparam int InWidth  = 16;
	localparam int OutFrac  = 14;
	localparam int OutWidth = 16;
	localparam int MagIn    = InWidth;                 // |c| width
	localparam int SumWidth = 2 * InWidth + 2;         // sum of four squares
	localparam int RadWidth = SumWidth + 16;           // sum * 2^16
	localparam int RootWidth = RadWidth / 2;           // magnitude width
	localparam int RootSteps = RootWidth;              // one root bit per cell
	localparam int QuoWidth  = OutFrac + 2;            // quotient incl. saturation room
	localparam int DivShift  = OutFrac + 8;
	localparam int NumWidth  = MagIn + DivShift;       // dividend width
	localparam int DivSteps  = QuoWidth;
	localparam int Lanes     = 4;

	localparam logic ModeQuat = 1'b0;
	localparam logic ModeVec  = 1'b1;
	localparam logic [31:0] MinSumReset = 32'd1;
	localparam logic [1:0] AddrMinSum = 2'd0;

	typedef logic [MagIn-1:0]     mag_t;
	typedef logic [RootWidth-1:0] root_t;
	typedef logic [RadWidth-1:0]  rad_t;

	// item traveling down the square-root chain
	typedef struct packed {
		logic                 degen;
		logic                 mode;
		logic [Lanes-1:0]     neg;
		mag_t [Lanes-1:0]     mag;
		rad_t                 rem;
		root_t                root;
	} sqrt_tok_t;

	// item traveling down the divider chain
	typedef struct packed {
		logic                      degen;
		logic                      mode;
		logic [Lanes-1:0]          neg;
		root_t                     div;
		logic [Lanes-1:0][RootWidth:0] rem;
		logic [Lanes-1:0][NumWidth-1:0] num;
		logic [Lanes-1:0][QuoWidth-1:0] quo;
	} div_tok_t;
endpackage

// ===== src/vqn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqn_in_if / vqn_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface vqn_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic signed [15:0] comp_x;
	logic signed [15:0] comp_y;
	logic signed [15:0] comp_z;
	logic signed [15:0] comp_w;
	modport source (output valid, mode, comp_x, comp_y, comp_z, comp_w, input ready);
	modport sink (input valid, mode, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface vqn_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] unit_x;
	logic signed [15:0] unit_y;
	logic signed [15:0] unit_z;
	logic signed [15:0] unit_w;
	logic degenerate;
	modport source (output valid, unit_x, unit_y, unit_z, unit_w, degenerate, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, unit_w, degenerate, output ready);
endinterface

// ===== src/vqn_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqn_sqrt_cell
// One restoring square-root step: decides one root bit and hands on.
// ----------------------------------------------------------------------------
module vqn_sqrt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [4:0]            step,
	input  logic                  vld_in,
	input  vqn_pkg::sqrt_tok_t    tok_in,
	output logic                  vld_out,
	output vqn_pkg::sqrt_tok_t    tok_out
);
	localparam int RW = vqn_pkg::RadWidth;
	logic [RW+1:0] trial;
	logic [RW+1:0] part;
	vqn_pkg::sqrt_tok_t nxt;

	// remainder window: rem bits above position 2*k, compare to 4*root+1
	always_comb begin
		int unsigned k;
		k = vqn_pkg::RootWidth - 1 - step;
		nxt = tok_in;
		part = {2'b00, tok_in.rem} >> (2 * k);
		trial = {{(RW - vqn_pkg::RootWidth){1'b0}}, tok_in.root, 2'b01};
		if (part >= trial) begin
			nxt.rem = tok_in.rem - RW'(trial << (2 * k));
			nxt.root = {tok_in.root[vqn_pkg::RootWidth-2:0], 1'b1};
		end else begin
			nxt.root = {tok_in.root[vqn_pkg::RootWidth-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_out <= nxt;
		end
	end
endmodule

// ===== src/vqn_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vqn_div_cell
// One restoring division step for all four lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module vqn_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  vqn_pkg::div_tok_t   tok_in,
	output logic                vld_out,
	output vqn_pkg::div_tok_t   tok_out
);
	localparam int RW = vqn_pkg::RootWidth;
	localparam int NW = vqn_pkg::NumWidth;
	vqn_pkg::div_tok_t nxt;
	logic [RW:0] shifted;

	always_comb begin
		nxt = tok_in;
		shifted = '0;
		for (int l = 0; l < vqn_pkg::Lanes; l++) begin
			shifted = {tok_in.rem[l][RW-1:0], tok_in.num[l][NW-1]};
			nxt.num[l] = {tok_in.num[l][NW-2:0], 1'b0};
			if (shifted >= {1'b0, tok_in.div}) begin
				nxt.rem[l] = shifted - {1'b0, tok_in.div};
				nxt.quo[l] = {tok_in.quo[l][vqn_pkg::QuoWidth-2:0], 1'b1};
			end else begin
				nxt.rem[l] = shifted;
				nxt.quo[l] = {tok_in.quo[l][vqn_pkg::QuoWidth-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_out <= nxt;
		end
	end
endmodule

// ===== src/vector_quaternion_normalize.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_quaternion_normalize
// Quaternion / three-vector normalizer with a threshold fallback.
// ----------------------------------------------------------------------------
// Accepts one request every cycle unless the output stalls. Each request passes
// through a square stage, a sum stage, a chain of 25 square-root cells (one
// root bit each), a chain of 38 divider cells that each shift in one dividend
// bit and decide one quotient bit for all four lanes (the leading 22 quotient
// bits are always zero and fall off the quotient), and the result register.
// The whole chain advances together and holds while the result register is
// full and not taken.
module vector_quaternion_normalize (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	vqn_in_if.sink       req,
	vqn_out_if.source    rsp
);
	localparam int L  = vqn_pkg::Lanes;
	localparam int RS = vqn_pkg::RootSteps;
	localparam int DS = vqn_pkg::NumWidth;

	logic [31:0] min_sum_q;
	logic        en;

	assign pready = 1'b1;
	assign prdata = (paddr == vqn_pkg::AddrMinSum) ? min_sum_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sum_q <= vqn_pkg::MinSumReset;
		end else if (psel && penable && pwrite && paddr == vqn_pkg::AddrMinSum) begin
			min_sum_q <= pwdata;
		end
	end

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// stage 1: magnitudes and squares
	logic                         vld_s1;
	logic                         mode_s1;
	logic [L-1:0]                 neg_s1;
	vqn_pkg::mag_t [L-1:0]        mag_s1;
	logic [L-1:0][2*vqn_pkg::MagIn-1:0] sq_s1;
	logic signed [15:0] c [L];

	assign c[0] = req.comp_x;
	assign c[1] = req.comp_y;
	assign c[2] = req.comp_z;
	assign c[3] = req.comp_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= req.mode;
			for (int l = 0; l < L; l++) begin
				logic [15:0] a;
				a = c[l][15] ? 16'(-c[l]) : 16'(c[l]);
				if (l == L - 1 && req.mode == vqn_pkg::ModeVec) begin
					a = '0;
				end
				neg_s1[l] <= c[l][15];
				mag_s1[l] <= a;
				sq_s1[l] <= 32'(a) * 32'(a);
			end
		end
	end

	// stage 2: sum and threshold
	logic               vld_s2;
	vqn_pkg::sqrt_tok_t tok_s2;
	logic [vqn_pkg::SumWidth-1:0] sum;

	assign sum = vqn_pkg::SumWidth'(sq_s1[0]) + vqn_pkg::SumWidth'(sq_s1[1])
		+ vqn_pkg::SumWidth'(sq_s1[2]) + vqn_pkg::SumWidth'(sq_s1[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tok_s2.degen <= (sum < vqn_pkg::SumWidth'(min_sum_q)) || (sum == '0);
			tok_s2.mode <= mode_s1;
			tok_s2.neg <= neg_s1;
			tok_s2.mag <= mag_s1;
			tok_s2.rem <= {sum, 16'd0};
			tok_s2.root <= '0;
		end
	end

	// square-root chain
	logic               sv [RS+1];
	vqn_pkg::sqrt_tok_t st [RS+1];
	assign sv[0] = vld_s2;
	assign st[0] = tok_s2;

	for (genvar g = 0; g < RS; g++) begin : g_sqrt
		vqn_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(g)),
			.vld_in(sv[g]), .tok_in(st[g]), .vld_out(sv[g+1]), .tok_out(st[g+1])
		);
	end

	// divider chain; the leading cells shift in dividend bits whose quotient
	// bits are always zero, but still run the same step
	logic              dv [DS+1];
	vqn_pkg::div_tok_t dt [DS+1];
	assign dv[0] = sv[RS];
	always_comb begin
		dt[0].degen = st[RS].degen;
		dt[0].mode  = st[RS].mode;
		dt[0].neg   = st[RS].neg;
		dt[0].div   = st[RS].root;
		for (int l = 0; l < L; l++) begin
			dt[0].rem[l] = '0;
			dt[0].num[l] = {st[RS].mag[l], vqn_pkg::DivShift'(0)};
			dt[0].quo[l] = '0;
		end
	end

	for (genvar g = 0; g < DS; g++) begin : g_div
		vqn_div_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv[g]), .tok_in(dt[g]), .vld_out(dv[g+1]), .tok_out(dt[g+1])
		);
	end

	// output register
	logic [L-1:0][15:0] res;
	always_comb begin
		for (int l = 0; l < L; l++) begin
			logic [15:0] q;
			q = (dt[DS].quo[l] > vqn_pkg::QuoWidth'(1 << vqn_pkg::OutFrac))
				? 16'(1 << vqn_pkg::OutFrac) : 16'(dt[DS].quo[l]);
			res[l] = dt[DS].neg[l] ? 16'(-q) : q;
			if (dt[DS].degen) begin
				res[l] = '0;
			end
		end
		if (dt[DS].mode == vqn_pkg::ModeVec) begin
			res[L-1] = '0;
		end else if (dt[DS].degen) begin
			res[L-1] = 16'(1 << vqn_pkg::OutFrac);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= dv[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.unit_x <= res[0];
			rsp.unit_y <= res[1];
			rsp.unit_z <= res[2];
			rsp.unit_w <= res[3];
			rsp.degenerate <= dt[DS].degen;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.unit_x))
		else $error("result dropped under stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ($signed(rsp.unit_x) <= 16384 && $signed(rsp.unit_x) >= -16384))
		else $error("unit_x out of range");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.degenerate |-> rsp.unit_x == 16'd0 && rsp.unit_y == 16'd0)
		else $error("fallback not applied");
endmodule
